### rtl/core/assert_macros.svh
// assertion macros used by the checker file stvg_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/stvg_pkg.sv
// shared types and constants for the simd twister variant generator
// no dependencies
package stvg_pkg;

   localparam int LANE_W = 32;
   localparam int LANES  = 4;
   localparam int ELEM_W = LANE_W * LANES;
   localparam int CSR_W  = 3;

   localparam logic [LANE_W-1:0] SEED_MULT = 32'd1812433253;

   localparam logic OP_RESEED = 1'b0;
   localparam logic OP_DRAW   = 1'b1;

   typedef enum logic [CSR_W-1:0] {
      CSR_MID_OFFSET  = 3'd0,
      CSR_LEFT_SHIFT  = 3'd1,
      CSR_RIGHT_SHIFT = 3'd2,
      CSR_BYTE_SHIFT  = 3'd3,
      CSR_MASK_LANE0  = 3'd4,
      CSR_MASK_LANE1  = 3'd5,
      CSR_MASK_LANE2  = 3'd6,
      CSR_MASK_LANE3  = 3'd7
   } csr_index_type;

   localparam logic [7:0]        RST_MID_OFFSET  = 8'd1;
   localparam logic [4:0]        RST_LEFT_SHIFT  = 5'd11;
   localparam logic [4:0]        RST_RIGHT_SHIFT = 5'd7;
   localparam logic [2:0]        RST_BYTE_SHIFT  = 3'd7;
   localparam logic [LANE_W-1:0] RST_MASK        = 32'd7;

   typedef struct packed {
      logic [7:0]                   mid_offset;
      logic [4:0]                   left_shift;
      logic [4:0]                   right_shift;
      logic [2:0]                   byte_shift;
      logic [LANES-1:0][LANE_W-1:0] mask_lane;
   } stvg_cfg_type;

   typedef struct packed {
      logic load;
      logic step;
   } seed_ctl_type;

   typedef struct packed {
      logic load;
      logic step;
   } recur_ctl_type;

endpackage

### rtl/core/stvg_ram.sv
// element store: one write port, two registered read ports
// depends on nothing
module stvg_ram #(
   parameter int DEPTH = 156,
   parameter int WIDTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

### rtl/core/stvg_seed.sv
// seeding unit: one lane of the seed recurrence per cycle while stepped, packs four lanes
// depends on stvg_pkg
module stvg_seed #(
   parameter int LW = 10
) (
   input  logic                       clock,
   input  stvg_pkg::seed_ctl_type     ctl,
   input  logic [stvg_pkg::LANE_W-1:0] seed,
   input  logic [LW-1:0]              lane,
   output logic [stvg_pkg::ELEM_W-1:0] wr_data
);
   import stvg_pkg::*;

   logic [LANE_W-1:0]             prev_ff;
   logic [LANE_W-1:0]             prev_in;
   logic [LANES-2:0][LANE_W-1:0]  buf_ff;
   logic [LANES-2:0][LANE_W-1:0]  buf_in;
   logic [LANE_W-1:0]             mixed;
   logic [LANE_W-1:0]             next_lane;

   always_comb begin
      mixed     = prev_ff ^ (prev_ff >> 30);
      next_lane = LANE_W'(SEED_MULT * mixed) + LANE_W'(lane);
      prev_in   = prev_ff;
      buf_in    = buf_ff;
      if (ctl.load) begin
         prev_in   = seed;
         buf_in[0] = seed;
      end else if (ctl.step) begin
         prev_in = next_lane;
         case (lane[1:0])
            2'd0:    buf_in[0] = next_lane;
            2'd1:    buf_in[1] = next_lane;
            2'd2:    buf_in[2] = next_lane;
            default: buf_in    = buf_ff;
         endcase
      end
   end

   assign wr_data = {next_lane, buf_ff};

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      buf_ff  <= buf_in;
   end

endmodule

### rtl/core/stvg_recur.sv
// regeneration datapath: masked xor-shift recursion over one element
// depends on stvg_pkg; keeps the two previous elements in registers
module stvg_recur (
   input  logic                        clock,
   input  stvg_pkg::recur_ctl_type     ctl,
   input  stvg_pkg::stvg_cfg_type      cfg,
   input  logic [stvg_pkg::ELEM_W-1:0] rd_a,
   input  logic [stvg_pkg::ELEM_W-1:0] rd_b,
   output logic [stvg_pkg::ELEM_W-1:0] new_elem
);
   import stvg_pkg::*;

   logic [ELEM_W-1:0] c_ff;
   logic [ELEM_W-1:0] c_in;
   logic [ELEM_W-1:0] d_ff;
   logic [ELEM_W-1:0] d_in;
   logic [ELEM_W-1:0] y;

   always_comb begin
      y = c_ff >> {cfg.byte_shift, 3'b000};
      for (int k = 0; k < LANES; k++) begin
         new_elem[k*LANE_W +: LANE_W] = rd_a[k*LANE_W +: LANE_W]
            ^ (rd_b[k*LANE_W +: LANE_W] & cfg.mask_lane[k])
            ^ (rd_b[k*LANE_W +: LANE_W] >> cfg.right_shift)
            ^ y[k*LANE_W +: LANE_W]
            ^ (d_ff[k*LANE_W +: LANE_W] << cfg.left_shift);
      end
   end

   always_comb begin
      c_in = c_ff;
      d_in = d_ff;
      if (ctl.load) begin
         c_in = rd_a;
         d_in = rd_b;
      end else if (ctl.step) begin
         c_in = d_ff;
         d_in = new_elem;
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      d_ff <= d_in;
   end

endmodule

### rtl/core/simd_twister_variant_generator_core.sv
// top level of the simd twister variant generator: control sequencer and registers
// depends on stvg_pkg, stvg_ram, stvg_seed, stvg_recur
//
// channel   ports                            handshake
// item in   start busy req_opcode req_seed   taken when start and not busy
// result    rsp_strobe rsp_value             one cycle, no back-pressure
// csr       csr_we csr_index csr_wdata       written when csr_we
//
// draw: one element store read, then the result cycle
// draw after the last element: adds a regeneration pass that first reduces mid_offset
// modulo STATE_WORDS, then does one store read and one write per element
// reseed: one lane multiply per cycle, no result
// reset leaves the store unseeded; draws then return zero without touching it
module simd_twister_variant_generator_core #(
   parameter int STATE_WORDS = 156
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_opcode,
   input  logic [stvg_pkg::LANE_W-1:0] req_seed,
   output logic                        rsp_strobe,
   output logic [stvg_pkg::LANE_W-1:0] rsp_value,
   input  logic                        csr_we,
   input  logic [stvg_pkg::CSR_W-1:0]  csr_index,
   input  logic [stvg_pkg::LANE_W-1:0] csr_wdata
);
   import stvg_pkg::*;

   localparam int IW = $clog2(STATE_WORDS);
   localparam int PW = $clog2(STATE_WORDS + 1);
   localparam int LW = $clog2(4 * STATE_WORDS);
   localparam int BW = (PW > 8) ? PW : 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_MODRED,
      ST_PREREAD,
      ST_PRELATCH,
      ST_READ,
      ST_WRITE,
      ST_DRAWRD,
      ST_OUT
   } state_type;

   state_type      state_ff, state_in;
   logic [PW-1:0]  ptr_ff, ptr_in;
   logic           seeded_ff, seeded_in;
   logic           zero_ff, zero_in;
   logic [LW-1:0]  lane_ff, lane_in;
   logic [IW-1:0]  elem_ff, elem_in;
   logic [BW-1:0]  bptr_ff, bptr_in;

   stvg_cfg_type   cfg_ff;
   seed_ctl_type   seed_ctl;
   recur_ctl_type  rec_ctl;

   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [ELEM_W-1:0] wr_data;
   logic [IW-1:0]     rd_addr_a;
   logic [IW-1:0]     rd_addr_b;
   logic [ELEM_W-1:0] rd_data_a;
   logic [ELEM_W-1:0] rd_data_b;
   logic [ELEM_W-1:0] seed_data;
   logic [ELEM_W-1:0] new_elem;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mid_offset  <= RST_MID_OFFSET;
         cfg_ff.left_shift  <= RST_LEFT_SHIFT;
         cfg_ff.right_shift <= RST_RIGHT_SHIFT;
         cfg_ff.byte_shift  <= RST_BYTE_SHIFT;
         cfg_ff.mask_lane   <= {LANES{RST_MASK}};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MID_OFFSET:  cfg_ff.mid_offset   <= csr_wdata[7:0];
            CSR_LEFT_SHIFT:  cfg_ff.left_shift   <= csr_wdata[4:0];
            CSR_RIGHT_SHIFT: cfg_ff.right_shift  <= csr_wdata[4:0];
            CSR_BYTE_SHIFT:  cfg_ff.byte_shift   <= csr_wdata[2:0];
            CSR_MASK_LANE0:  cfg_ff.mask_lane[0] <= csr_wdata;
            CSR_MASK_LANE1:  cfg_ff.mask_lane[1] <= csr_wdata;
            CSR_MASK_LANE2:  cfg_ff.mask_lane[2] <= csr_wdata;
            CSR_MASK_LANE3:  cfg_ff.mask_lane[3] <= csr_wdata;
            default:         cfg_ff              <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      seeded_in = seeded_ff;
      zero_in   = zero_ff;
      lane_in   = lane_ff;
      elem_in   = elem_ff;
      bptr_in   = bptr_ff;
      seed_ctl  = '0;
      rec_ctl   = '0;
      wr_en     = 1'b0;
      wr_addr   = elem_ff;
      wr_data   = new_elem;
      rd_addr_a = ptr_ff[IW-1:0];
      rd_addr_b = elem_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_opcode == OP_RESEED) begin
                  seed_ctl.load = 1'b1;
                  lane_in       = LW'(1);
                  state_in      = ST_SEED;
               end else if (!seeded_ff) begin
                  zero_in  = 1'b1;
                  state_in = ST_OUT;
               end else if (ptr_ff == PW'(STATE_WORDS)) begin
                  bptr_in  = BW'(cfg_ff.mid_offset);
                  state_in = ST_MODRED;
               end else begin
                  zero_in  = 1'b0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_SEED: begin
            seed_ctl.step = 1'b1;
            wr_en         = (lane_ff[1:0] == 2'd3);
            wr_addr       = lane_ff[LW-1:2];
            wr_data       = seed_data;
            lane_in       = lane_ff + LW'(1);
            if (lane_ff == LW'(4 * STATE_WORDS - 1)) begin
               seeded_in = 1'b1;
               ptr_in    = '0;
               state_in  = ST_IDLE;
            end
         end
         ST_MODRED: begin
            // middle offset taken modulo the store depth
            if (bptr_ff >= BW'(STATE_WORDS)) begin
               bptr_in = bptr_ff - BW'(STATE_WORDS);
            end else begin
               state_in = ST_PREREAD;
            end
         end
         ST_PREREAD: begin
            rd_addr_a = IW'(STATE_WORDS - 2);
            rd_addr_b = IW'(STATE_WORDS - 1);
            state_in  = ST_PRELATCH;
         end
         ST_PRELATCH: begin
            rec_ctl.load = 1'b1;
            elem_in      = '0;
            state_in     = ST_READ;
         end
         ST_READ: begin
            rd_addr_a = elem_ff;
            rd_addr_b = bptr_ff[IW-1:0];
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            rec_ctl.step = 1'b1;
            wr_en        = 1'b1;
            if (bptr_ff == BW'(STATE_WORDS - 1)) begin
               bptr_in = '0;
            end else begin
               bptr_in = bptr_ff + BW'(1);
            end
            if (elem_ff == IW'(STATE_WORDS - 1)) begin
               state_in = ST_DRAWRD;
            end else begin
               elem_in  = elem_ff + IW'(1);
               state_in = ST_READ;
            end
         end
         ST_DRAWRD: begin
            rd_addr_a = '0;
            ptr_in    = '0;
            zero_in   = 1'b0;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!zero_ff) begin
               ptr_in = ptr_ff + PW'(1);
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ptr_ff    <= '0;
         seeded_ff <= 1'b0;
         zero_ff   <= 1'b0;
         lane_ff   <= '0;
         elem_ff   <= '0;
         bptr_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         seeded_ff <= seeded_in;
         zero_ff   <= zero_in;
         lane_ff   <= lane_in;
         elem_ff   <= elem_in;
         bptr_ff   <= bptr_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_OUT);
   assign rsp_value  = zero_ff ? '0 : rd_data_a[LANE_W-1:0];

   stvg_ram #(
      .DEPTH (STATE_WORDS),
      .WIDTH (ELEM_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   stvg_seed #(
      .LW (LW)
   ) u_seed (
      .clock   (clock),
      .ctl     (seed_ctl),
      .seed    (req_seed),
      .lane    (lane_ff),
      .wr_data (seed_data)
   );

   stvg_recur u_recur (
      .clock    (clock),
      .ctl      (rec_ctl),
      .cfg      (cfg_ff),
      .rd_a     (rd_data_a),
      .rd_b     (rd_data_b),
      .new_elem (new_elem)
   );

endmodule

### rtl/core/stvg_checker.sv
// port-level checks for the generator core, bound to the top level
// depends on stvg_pkg and assert_macros.svh
`include "assert_macros.svh"

module stvg_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_opcode,
   input logic rsp_strobe
);
   import stvg_pkg::*;

   logic accept;

   assign accept = start && !busy;

   // every accepted item makes the block busy once it is taken
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "item accepted but block not busy")
   `ASSERT_SAME(a_strobe_busy, clock, reset, rsp_strobe, busy, "result shown while idle")
   `ASSERT_NEXT(a_strobe_ends, clock, reset, rsp_strobe, !busy, "block still busy after result")
   `ASSERT_NEXT(a_reseed_quiet, clock, reset, accept && (req_opcode == OP_RESEED),
      !rsp_strobe, "reseed item gave a result")

endmodule

bind simd_twister_variant_generator_core stvg_checker u_stvg_checker (.*);
